@@ rtl/core/bhp_pkg.sv @@
// Shared constants, register codes and inter-stage types of the bilinear heat-map pixel block
package bhp_pkg;

	// Field widths
	localparam int COORD_BITS = 12;
	localparam int FRAC_BITS  = 16;
	localparam int CHAN_W     = 8;
	localparam int HUE_W      = 9;
	localparam int SECTOR_W   = 3;
	localparam int RAMP_W     = 6;

	// Interpolation datapath widths
	localparam int DIFF_W = COORD_BITS + 1;
	localparam int AREA_W = 2 * COORD_BITS + 1;
	localparam int DEN_W  = 2 * COORD_BITS;
	localparam int TERM_W = AREA_W + FRAC_BITS;
	localparam int NUM_W  = TERM_W + 2;
	localparam int MAG_W  = NUM_W - 1;
	localparam int REM_W  = DEN_W + FRAC_BITS;

	// Port widths
	localparam int IDX_W = 3;
	localparam int CFG_W = (COORD_BITS > FRAC_BITS) ? COORD_BITS : FRAC_BITS;
	localparam int IN_W  = ((2 * COORD_BITS + 7) / 8) * 8;
	localparam int OUT_W = ((FRAC_BITS + 3 * CHAN_W + 7) / 8) * 8;

	// Colour map constants
	localparam int FRAC_ONE    = 1 << FRAC_BITS;
	localparam int HUE_MAX     = 359;
	localparam int CHAN_MAX    = 255;
	localparam int SECTOR_SPAN = 60;
	// hue / 60 as a multiply by a rounded-up reciprocal, exact for hue <= 359
	localparam int RECIP_SH    = 16;
	localparam int HUE_RECIP   = (1 << RECIP_SH) / SECTOR_SPAN + 1;
	// (f*255 + 30) / 60 reduces to (17*f + 2) / 4
	localparam int RAMP_MUL    = 4 * CHAN_MAX / SECTOR_SPAN;
	localparam int RAMP_BIAS   = 2 * (SECTOR_SPAN / 2) * 4 / (2 * SECTOR_SPAN);

	// Register reset values
	localparam int RST_LEFT_X   = 0;
	localparam int RST_TOP_Y    = 0;
	localparam int RST_RIGHT_X  = 800;
	localparam int RST_BOTTOM_Y = 600;
	localparam int RST_VALUE_TL = 65535;
	localparam int RST_VALUE_TR = 32768;
	localparam int RST_VALUE_BR = 65535;
	localparam int RST_VALUE_BL = 0;

	typedef enum logic [IDX_W-1:0] {
		REG_LEFT_X   = 3'd0,
		REG_TOP_Y    = 3'd1,
		REG_RIGHT_X  = 3'd2,
		REG_BOTTOM_Y = 3'd3,
		REG_VALUE_TL = 3'd4,
		REG_VALUE_TR = 3'd5,
		REG_VALUE_BR = 3'd6,
		REG_VALUE_BL = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] left_x;
		logic [COORD_BITS-1:0] top_y;
		logic [COORD_BITS-1:0] right_x;
		logic [COORD_BITS-1:0] bottom_y;
		logic [FRAC_BITS-1:0]  v_tl;
		logic [FRAC_BITS-1:0]  v_tr;
		logic [FRAC_BITS-1:0]  v_br;
		logic [FRAC_BITS-1:0]  v_bl;
	} cfg_t;

	// Rectangle area as seen by the divider
	typedef struct packed {
		logic [DEN_W-1:0] mag;
		logic             neg;
		logic             degen;
	} den_t;

	typedef struct packed {
		logic [FRAC_BITS-1:0] level;
		logic                 degen;
	} level_t;

	typedef struct packed {
		logic [FRAC_BITS-1:0] level;
		logic [CHAN_W-1:0]    red;
		logic [CHAN_W-1:0]    green;
		logic [CHAN_W-1:0]    blue;
		logic                 degen;
	} pixel_t;

endpackage

@@ rtl/core/bhp_interp.sv @@
// Bilinear numerator pipeline: corner distances, area weights, weighted terms, sum
module bhp_interp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  bhp_pkg::cfg_t                       cfg,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [bhp_pkg::COORD_BITS-1:0]      px,
	input  logic [bhp_pkg::COORD_BITS-1:0]      py,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [bhp_pkg::NUM_W-1:0]    num
);
	import bhp_pkg::*;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic adv_s1, adv_s2, adv_s3, adv_s4, adv_s5;

	logic signed [DIFF_W-1:0]   dxr_s1, dxl_s1, dyb_s1, dyt_s1;
	logic signed [AREA_W-1:0]   a_tl_s2, a_tr_s2, a_bl_s2, a_br_s2;
	logic signed [TERM_W-1:0]   t_tl_s3, t_tr_s3, t_bl_s3, t_br_s3;
	logic signed [TERM_W:0]     top_s4, bot_s4;
	logic signed [NUM_W-1:0]    num_s5;

	logic signed [2*DIFF_W-1:0] p_tl, p_tr, p_bl, p_br;
	logic signed [TERM_W:0]     w_tl, w_tr, w_bl, w_br;

	// Advance a stage when it is empty or its content moves on
	assign adv_s5   = !vld_s5 || out_ready;
	assign adv_s4   = !vld_s4 || adv_s5;
	assign adv_s3   = !vld_s3 || adv_s4;
	assign adv_s2   = !vld_s2 || adv_s3;
	assign adv_s1   = !vld_s1 || adv_s2;
	assign in_ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (adv_s1) vld_s1 <= in_valid;
			if (adv_s2) vld_s2 <= vld_s1;
			if (adv_s3) vld_s3 <= vld_s2;
			if (adv_s4) vld_s4 <= vld_s3;
			if (adv_s5) vld_s5 <= vld_s4;
		end
	end

	// Area weights of each corner
	assign p_tl = dxr_s1 * dyb_s1;
	assign p_tr = dxl_s1 * dyb_s1;
	assign p_bl = dxr_s1 * dyt_s1;
	assign p_br = dxl_s1 * dyt_s1;

	// Weighted corner values
	assign w_tl = a_tl_s2 * $signed({1'b0, cfg.v_tl});
	assign w_tr = a_tr_s2 * $signed({1'b0, cfg.v_tr});
	assign w_bl = a_bl_s2 * $signed({1'b0, cfg.v_bl});
	assign w_br = a_br_s2 * $signed({1'b0, cfg.v_br});

	always_ff @(posedge clk) begin
		// Signed distances to the rectangle edges
		if (adv_s1) begin
			dxr_s1 <= $signed({1'b0, cfg.right_x}) - $signed({1'b0, px});
			dxl_s1 <= $signed({1'b0, px}) - $signed({1'b0, cfg.left_x});
			dyb_s1 <= $signed({1'b0, cfg.bottom_y}) - $signed({1'b0, py});
			dyt_s1 <= $signed({1'b0, py}) - $signed({1'b0, cfg.top_y});
		end
		if (adv_s2) begin
			a_tl_s2 <= p_tl[AREA_W-1:0];
			a_tr_s2 <= p_tr[AREA_W-1:0];
			a_bl_s2 <= p_bl[AREA_W-1:0];
			a_br_s2 <= p_br[AREA_W-1:0];
		end
		if (adv_s3) begin
			t_tl_s3 <= w_tl[TERM_W-1:0];
			t_tr_s3 <= w_tr[TERM_W-1:0];
			t_bl_s3 <= w_bl[TERM_W-1:0];
			t_br_s3 <= w_br[TERM_W-1:0];
		end
		// Sum in a two-level tree
		if (adv_s4) begin
			top_s4 <= (TERM_W+1)'(t_tl_s3) + (TERM_W+1)'(t_tr_s3);
			bot_s4 <= (TERM_W+1)'(t_bl_s3) + (TERM_W+1)'(t_br_s3);
		end
		if (adv_s5) begin
			num_s5 <= NUM_W'(top_s4) + NUM_W'(bot_s4);
		end
	end

	assign out_valid = vld_s5;
	assign num       = num_s5;

endmodule

@@ rtl/core/bhp_divide.sv @@
// Pipelined restoring divider: numerator over rectangle area, one quotient bit per stage
module bhp_divide (
	input  logic                              clk,
	input  logic                              arst_n,
	input  bhp_pkg::den_t                     den,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [bhp_pkg::NUM_W-1:0]  num,
	output logic                              out_valid,
	input  logic                              out_ready,
	output bhp_pkg::level_t                   res
);
	import bhp_pkg::*;

	// Sign fix-up, overflow check, one stage per quotient bit, result
	localparam int NST = FRAC_BITS + 3;

	typedef struct packed {
		logic [REM_W-1:0]     rem;
		logic [FRAC_BITS-1:0] quo;
		logic                 ovf;
		logic                 nonpos;
	} div_stage_t;

	logic [NST-1:0]          vld_s;
	logic [NST:0]            adv;

	logic [MAG_W-1:0]        mag_s1;
	logic                    nonpos_s1;
	div_stage_t              div_s [0:FRAC_BITS];
	div_stage_t              step  [1:FRAC_BITS];
	level_t                  res_s;

	logic signed [NUM_W-1:0] num_fix;
	logic                    ovf;

	// Advance a stage when it is empty or its content moves on
	assign adv[NST] = out_ready;
	for (genvar i = 0; i < NST; i++) begin : g_adv
		assign adv[i] = !vld_s[i] || adv[i+1];
	end
	assign in_ready = adv[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (adv[0]) vld_s[0] <= in_valid;
			for (int i = 1; i < NST; i++) begin
				if (adv[i]) vld_s[i] <= vld_s[i-1];
			end
		end
	end

	// Flip the numerator when the area is negative
	assign num_fix = den.neg ? -num : num;

	// Quotient would not fit the fraction: saturate
	assign ovf = mag_s1 >= MAG_W'({den.mag, {FRAC_BITS{1'b0}}});

	// Trial subtraction of the shifted divisor, highest bit first
	always_comb begin
		for (int k = 1; k <= FRAC_BITS; k++) begin
			step[k] = div_s[k-1];
			if (div_s[k-1].rem >= (REM_W'(den.mag) << (FRAC_BITS - k))) begin
				step[k].rem = div_s[k-1].rem - (REM_W'(den.mag) << (FRAC_BITS - k));
				step[k].quo[FRAC_BITS-k] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			mag_s1    <= num_fix[MAG_W-1:0];
			nonpos_s1 <= num_fix[NUM_W-1] || (num_fix == '0);
		end
		if (adv[1]) begin
			div_s[0].rem    <= mag_s1[REM_W-1:0];
			div_s[0].quo    <= '0;
			div_s[0].ovf    <= ovf;
			div_s[0].nonpos <= nonpos_s1;
		end
		for (int k = 1; k <= FRAC_BITS; k++) begin
			if (adv[k+1]) div_s[k] <= step[k];
		end
		// Clamp to 0 .. 1 and force zero on an empty rectangle
		if (adv[NST-1]) begin
			if (den.degen || div_s[FRAC_BITS].nonpos) begin
				res_s.level <= '0;
			end else if (div_s[FRAC_BITS].ovf) begin
				res_s.level <= '1;
			end else begin
				res_s.level <= div_s[FRAC_BITS].quo;
			end
			res_s.degen <= den.degen;
		end
	end

	assign out_valid = vld_s[NST-1];
	assign res       = res_s;

endmodule

@@ rtl/core/bhp_colour.sv @@
// Level to hue, hue to six-sector RGB colour map pipeline
module bhp_colour (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  bhp_pkg::level_t lvl,
	output logic            out_valid,
	input  logic            out_ready,
	output bhp_pkg::pixel_t pix
);
	import bhp_pkg::*;

	typedef enum logic [SECTOR_W-1:0] {
		SEC_RED_GREEN_UP    = 3'd0,
		SEC_GREEN_RED_DOWN  = 3'd1,
		SEC_GREEN_BLUE_UP   = 3'd2,
		SEC_BLUE_GREEN_DOWN = 3'd3,
		SEC_BLUE_RED_UP     = 3'd4,
		SEC_RED_BLUE_DOWN   = 3'd5
	} sector_t;

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic adv_s1, adv_s2, adv_s3, adv_s4;

	logic [HUE_W-1:0]          hue_s1, hue_s2;
	logic [SECTOR_W-1:0]       sector_s2;
	sector_t                   sector_s3;
	logic [CHAN_W-1:0]         up_s3, down_s3;
	level_t                    lvl_s1, lvl_s2, lvl_s3;
	pixel_t                    pix_s4;

	logic [FRAC_BITS:0]        span;
	logic [FRAC_BITS+HUE_W:0]  hue_prod;
	logic [HUE_W+RECIP_SH-1:0] sec_prod;
	logic [HUE_W-1:0]          sec_base;
	logic [HUE_W-1:0]          frac_full;
	logic [RAMP_W-1:0]         frac;
	logic [CHAN_W+1:0]         ramp_x4;

	// Advance a stage when it is empty or its content moves on
	assign adv_s4   = !vld_s4 || out_ready;
	assign adv_s3   = !vld_s3 || adv_s4;
	assign adv_s2   = !vld_s2 || adv_s3;
	assign adv_s1   = !vld_s1 || adv_s2;
	assign in_ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (adv_s1) vld_s1 <= in_valid;
			if (adv_s2) vld_s2 <= vld_s1;
			if (adv_s3) vld_s3 <= vld_s2;
			if (adv_s4) vld_s4 <= vld_s3;
		end
	end

	// hue = (1 - level) * 359, truncated
	assign span     = (FRAC_BITS+1)'(FRAC_ONE) - {1'b0, lvl.level};
	assign hue_prod = (FRAC_BITS+HUE_W+1)'(span) * (FRAC_BITS+HUE_W+1)'(HUE_MAX);

	// Sector by reciprocal multiply
	assign sec_prod = (HUE_W+RECIP_SH)'(hue_s1) * (HUE_W+RECIP_SH)'(HUE_RECIP);

	// Position within the sector and rounded ramp value
	assign sec_base  = HUE_W'(sector_s2) * HUE_W'(SECTOR_SPAN);
	assign frac_full = hue_s2 - sec_base;
	assign frac      = frac_full[RAMP_W-1:0];
	assign ramp_x4   = (CHAN_W+2)'(frac) * (CHAN_W+2)'(RAMP_MUL) + (CHAN_W+2)'(RAMP_BIAS);

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			hue_s1 <= hue_prod[FRAC_BITS+HUE_W-1:FRAC_BITS];
			lvl_s1 <= lvl;
		end
		if (adv_s2) begin
			hue_s2    <= hue_s1;
			sector_s2 <= sec_prod[RECIP_SH+SECTOR_W-1:RECIP_SH];
			lvl_s2    <= lvl_s1;
		end
		if (adv_s3) begin
			sector_s3 <= sector_t'(sector_s2);
			up_s3     <= ramp_x4[CHAN_W+1:2];
			down_s3   <= CHAN_W'(CHAN_MAX) - ramp_x4[CHAN_W+1:2];
			lvl_s3    <= lvl_s2;
		end
		// Select the channel pattern of the sector
		if (adv_s4) begin
			pix_s4.level <= lvl_s3.level;
			pix_s4.degen <= lvl_s3.degen;
			case (sector_s3)
				SEC_RED_GREEN_UP: begin
					pix_s4.red   <= CHAN_W'(CHAN_MAX);
					pix_s4.green <= up_s3;
					pix_s4.blue  <= '0;
				end
				SEC_GREEN_RED_DOWN: begin
					pix_s4.red   <= down_s3;
					pix_s4.green <= CHAN_W'(CHAN_MAX);
					pix_s4.blue  <= '0;
				end
				SEC_GREEN_BLUE_UP: begin
					pix_s4.red   <= '0;
					pix_s4.green <= CHAN_W'(CHAN_MAX);
					pix_s4.blue  <= up_s3;
				end
				SEC_BLUE_GREEN_DOWN: begin
					pix_s4.red   <= '0;
					pix_s4.green <= down_s3;
					pix_s4.blue  <= CHAN_W'(CHAN_MAX);
				end
				SEC_BLUE_RED_UP: begin
					pix_s4.red   <= up_s3;
					pix_s4.green <= '0;
					pix_s4.blue  <= CHAN_W'(CHAN_MAX);
				end
				default: begin
					pix_s4.red   <= CHAN_W'(CHAN_MAX);
					pix_s4.green <= '0;
					pix_s4.blue  <= down_s3;
				end
			endcase
		end
	end

	assign out_valid = vld_s4;
	assign pix       = pix_s4;

`ifndef SYNTHESIS
	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> hue_s1 <= HUE_W'(HUE_MAX))
		else $error("hue beyond its range");

	a_sector_high: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> sector_s2 <= SECTOR_W'(HUE_MAX / SECTOR_SPAN))
		else $error("sector beyond the last one");

	a_sector_low: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> frac_full < HUE_W'(SECTOR_SPAN))
		else $error("sector too low for its hue");
`endif

endmodule

@@ rtl/core/bilinear_heatmap_pixel.sv @@
// Throughput: one pixel per cycle while m_tready is high; every stage holds one request
// and stalls only when full. The divider resolves one quotient bit per register stage.
// Reset: arst_n clears all valid bits and loads the register defaults; the rectangle area
// seen by the divider follows a register write through the area_q and den_q registers.
module bilinear_heatmap_pixel (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [bhp_pkg::IDX_W-1:0]      cfg_index,
	input  logic [bhp_pkg::CFG_W-1:0]      cfg_data,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// pixel_x, pixel_y
	input  logic [bhp_pkg::IN_W-1:0]       s_tdata,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// level, red, green, blue
	output logic [bhp_pkg::OUT_W-1:0]      m_tdata,
	// degenerate
	output logic                           m_tuser
);
	import bhp_pkg::*;

	cfg_t                     cfg_q;
	logic signed [AREA_W-1:0] area_q;
	den_t                     den_q;

	logic signed [DIFF_W-1:0]   span_x, span_y;
	logic signed [2*DIFF_W-1:0] area_full;

	logic signed [NUM_W-1:0] num;
	logic                    num_valid, num_ready;
	level_t                  lvl;
	logic                    lvl_valid, lvl_ready;
	pixel_t                  pix;

	assign cfg_ready = 1'b1;

	// Register writes, upper data bits dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.left_x   <= COORD_BITS'(RST_LEFT_X);
			cfg_q.top_y    <= COORD_BITS'(RST_TOP_Y);
			cfg_q.right_x  <= COORD_BITS'(RST_RIGHT_X);
			cfg_q.bottom_y <= COORD_BITS'(RST_BOTTOM_Y);
			cfg_q.v_tl     <= FRAC_BITS'(RST_VALUE_TL);
			cfg_q.v_tr     <= FRAC_BITS'(RST_VALUE_TR);
			cfg_q.v_br     <= FRAC_BITS'(RST_VALUE_BR);
			cfg_q.v_bl     <= FRAC_BITS'(RST_VALUE_BL);
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_LEFT_X:   cfg_q.left_x   <= cfg_data[COORD_BITS-1:0];
				REG_TOP_Y:    cfg_q.top_y    <= cfg_data[COORD_BITS-1:0];
				REG_RIGHT_X:  cfg_q.right_x  <= cfg_data[COORD_BITS-1:0];
				REG_BOTTOM_Y: cfg_q.bottom_y <= cfg_data[COORD_BITS-1:0];
				REG_VALUE_TL: cfg_q.v_tl     <= cfg_data[FRAC_BITS-1:0];
				REG_VALUE_TR: cfg_q.v_tr     <= cfg_data[FRAC_BITS-1:0];
				REG_VALUE_BR: cfg_q.v_br     <= cfg_data[FRAC_BITS-1:0];
				REG_VALUE_BL: cfg_q.v_bl     <= cfg_data[FRAC_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Rectangle area, then its magnitude and sign for the divider
	assign span_x    = $signed({1'b0, cfg_q.right_x}) - $signed({1'b0, cfg_q.left_x});
	assign span_y    = $signed({1'b0, cfg_q.bottom_y}) - $signed({1'b0, cfg_q.top_y});
	assign area_full = span_x * span_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			area_q      <= '0;
			den_q.mag   <= '0;
			den_q.neg   <= 1'b0;
			den_q.degen <= 1'b1;
		end else begin
			area_q      <= area_full[AREA_W-1:0];
			den_q.mag   <= area_q[AREA_W-1] ? DEN_W'(-area_q) : DEN_W'(area_q);
			den_q.neg   <= area_q[AREA_W-1];
			den_q.degen <= (area_q == '0);
		end
	end

	bhp_interp u_interp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.px        (s_tdata[COORD_BITS-1:0]),
		.py        (s_tdata[2*COORD_BITS-1:COORD_BITS]),
		.out_valid (num_valid),
		.out_ready (num_ready),
		.num       (num)
	);

	bhp_divide u_divide (
		.clk       (clk),
		.arst_n    (arst_n),
		.den       (den_q),
		.in_valid  (num_valid),
		.in_ready  (num_ready),
		.num       (num),
		.out_valid (lvl_valid),
		.out_ready (lvl_ready),
		.res       (lvl)
	);

	bhp_colour u_colour (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (lvl_valid),
		.in_ready  (lvl_ready),
		.lvl       (lvl),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.pix       (pix)
	);

	assign m_tdata = OUT_W'({pix.blue, pix.green, pix.red, pix.level});
	assign m_tuser = pix.degen;

`ifndef SYNTHESIS
	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no result waiting");

	a_degen_colour: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && pix.degen) |-> (pix.level == '0 && pix.red == CHAN_W'(CHAN_MAX)
			&& pix.green == '0))
		else $error("empty rectangle gave a non-zero level or wrong colour");

	a_full_level_red: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && pix.level == '1) |-> (pix.red == CHAN_W'(CHAN_MAX)
			&& pix.green == '0 && pix.blue == '0))
		else $error("full level not mapped to pure red");
`endif

endmodule
